// File: design/ray_plane_intersect_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef RAY_PLANE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_PLANE_INTERSECT_UNIT_DEFINES_SVH

// The antecedent holds in the same cycle as the consequent.
`define RPI_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPI_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("%m: check failed");

`endif

// File: design/rpi_pkg.sv
package rpi_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic               check_on_plane;
  } rpi_in_t;

  typedef struct packed {
    logic        [1:0]  side;
    logic        [1:0]  hit_kind;
    logic        [30:0] distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } rpi_out_t;

  localparam logic [1:0] SIDE_NEG = 2'd0;
  localparam logic [1:0] SIDE_POS = 2'd1;
  localparam logic [1:0] SIDE_ON  = 2'd2;

  localparam logic [1:0] KIND_HIT      = 2'd0;
  localparam logic [1:0] KIND_PARALLEL = 2'd1;
  localparam logic [1:0] KIND_BEHIND   = 2'd2;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_SIDE_TOL = 3'd6,
    REG_PAR_TOL  = 3'd7
  } rpi_reg_e;

  localparam int QBITS = 31;
  localparam int NUMW  = 97;
  localparam int DENW  = 66;
  localparam logic [30:0] DIST_MAX = 31'h7fffffff;

endpackage

// File: design/ray_plane_intersect_unit.sv
// Ray-plane test in signed Q16.16. One beat enters per cycle while the output is not stalled,
// and its result passes through an offset stage, a multiplier stage, an adder stage,
// a classify stage, 31 divider stages that each resolve one quotient bit of the distance, a
// hit-point multiplier stage and the output register. A stalled output holds the pipeline
// while empty stages still fill. Plane registers are to be written by the user over the APB
// port only while the block is idle; the block itself does not enforce this.
module ray_plane_intersect_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rpi_pkg::rpi_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rpi_pkg::rpi_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rpi_pkg::*;

  typedef struct packed {
    logic signed [32:0] dp_x;
    logic signed [32:0] dp_y;
    logic signed [32:0] dp_z;
    rpi_in_t            in;
  } s1_t;

  typedef struct packed {
    logic signed [64:0] kp_x;
    logic signed [64:0] kp_y;
    logic signed [64:0] kp_z;
    logic signed [63:0] lp_x;
    logic signed [63:0] lp_y;
    logic signed [63:0] lp_z;
    rpi_in_t            in;
  } s2_t;

  typedef struct packed {
    logic signed [66:0] k;
    logic signed [65:0] l;
    rpi_in_t            in;
  } s3_t;

  typedef struct packed {
    logic [1:0]       side;
    logic [1:0]       kind;
    logic             sat;
    logic [NUMW-1:0]  rem;
    logic [DENW-1:0]  den;
    logic [QBITS-1:0] q;
    rpi_in_t          in;
  } div_t;

  typedef struct packed {
    logic signed [63:0] pr_x;
    logic signed [63:0] pr_y;
    logic signed [63:0] pr_z;
    logic [1:0]         side;
    logic [1:0]         kind;
    logic [30:0]        dist_val;
    rpi_in_t            in;
  } s5_t;

  logic signed [31:0] org_x_q, org_y_q, org_z_q;
  logic signed [31:0] nrm_x_q, nrm_y_q, nrm_z_q;
  logic [30:0]        stol_q, ptol_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      nrm_x_q <= 32'sd65536;
      nrm_y_q <= '0;
      nrm_z_q <= '0;
      stol_q  <= '0;
      ptol_q  <= '0;
    end else if (cfg_wr) begin
      case (rpi_reg_e'(paddr[4:2]))
        REG_ORIGIN_X: org_x_q <= pwdata;
        REG_ORIGIN_Y: org_y_q <= pwdata;
        REG_ORIGIN_Z: org_z_q <= pwdata;
        REG_NORMAL_X: nrm_x_q <= pwdata;
        REG_NORMAL_Y: nrm_y_q <= pwdata;
        REG_NORMAL_Z: nrm_z_q <= pwdata;
        REG_SIDE_TOL: stol_q  <= pwdata[30:0];
        REG_PAR_TOL:  ptol_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rpi_reg_e'(paddr[4:2]))
      REG_ORIGIN_X: prdata = org_x_q;
      REG_ORIGIN_Y: prdata = org_y_q;
      REG_ORIGIN_Z: prdata = org_z_q;
      REG_NORMAL_X: prdata = nrm_x_q;
      REG_NORMAL_Y: prdata = nrm_y_q;
      REG_NORMAL_Z: prdata = nrm_z_q;
      REG_SIDE_TOL: prdata = {1'b0, stol_q};
      REG_PAR_TOL:  prdata = {1'b0, ptol_q};
      default:      prdata = '0;
    endcase
  end

  logic             v1_q, v2_q, v3_q, v5_q, vo_q;
  logic [QBITS:0]   vd_q;
  logic             en1, en2, en3, en5, en_o;
  logic [QBITS:0]   en_d;
  s1_t              s1_q, s1_d;
  s2_t              s2_q, s2_d;
  s3_t              s3_q, s3_d;
  div_t             d_q [QBITS+1];
  div_t             d0_d;
  s5_t              s5_q, s5_d;
  rpi_out_t         o_q, o_d;

  assign en_o        = !vo_q || out_ready_i;
  assign en5         = !v5_q || en_o;
  assign en_d[QBITS] = !vd_q[QBITS] || en5;
  for (genvar j = 0; j < QBITS; j++) begin : g_en
    assign en_d[j] = !vd_q[j] || en_d[j+1];
  end
  assign en3        = !v3_q || en_d[0];
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    s1_d.dp_x = {in_data_i.pos_x[31], in_data_i.pos_x} - {org_x_q[31], org_x_q};
    s1_d.dp_y = {in_data_i.pos_y[31], in_data_i.pos_y} - {org_y_q[31], org_y_q};
    s1_d.dp_z = {in_data_i.pos_z[31], in_data_i.pos_z} - {org_z_q[31], org_z_q};
    s1_d.in   = in_data_i;
  end

  always_comb begin
    s2_d.kp_x = s1_q.dp_x * nrm_x_q;
    s2_d.kp_y = s1_q.dp_y * nrm_y_q;
    s2_d.kp_z = s1_q.dp_z * nrm_z_q;
    s2_d.lp_x = s1_q.in.dir_x * nrm_x_q;
    s2_d.lp_y = s1_q.in.dir_y * nrm_y_q;
    s2_d.lp_z = s1_q.in.dir_z * nrm_z_q;
    s2_d.in   = s1_q.in;
  end

  always_comb begin
    s3_d.k  = 67'(s2_q.kp_x) + 67'(s2_q.kp_y) + 67'(s2_q.kp_z);
    s3_d.l  = 66'(s2_q.lp_x) + 66'(s2_q.lp_y) + 66'(s2_q.lp_z);
    s3_d.in = s2_q.in;
  end

  logic            k_neg, k_zero, l_neg, l_zero;
  logic [66:0]     abs_k;
  logic [DENW-1:0] abs_l;

  always_comb begin
    k_neg  = s3_q.k[66];
    k_zero = (s3_q.k == '0);
    l_neg  = s3_q.l[65];
    l_zero = (s3_q.l == '0);
    abs_k  = k_neg ? 67'(-s3_q.k) : 67'(s3_q.k);
    abs_l  = l_neg ? 66'(-s3_q.l) : 66'(s3_q.l);
    if (s3_q.in.check_on_plane && (abs_k <= 67'({stol_q, 16'b0}))) begin
      d0_d.side = SIDE_ON;
    end else if (!k_neg && !k_zero) begin
      d0_d.side = SIDE_POS;
    end else begin
      d0_d.side = SIDE_NEG;
    end
    if ((abs_l <= 66'({ptol_q, 16'b0})) || l_zero) begin
      d0_d.kind = KIND_PARALLEL;
    end else if (k_zero || (k_neg == l_neg)) begin
      d0_d.kind = KIND_BEHIND;
    end else begin
      d0_d.kind = KIND_HIT;
    end
    d0_d.rem = NUMW'({abs_k, 16'b0});
    d0_d.den = abs_l;
    d0_d.sat = (d0_d.rem >= (NUMW'(abs_l) << QBITS));
    d0_d.q   = '0;
    d0_d.in  = s3_q.in;
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int B = QBITS - 1 - j;
    div_t            nx;
    logic [NUMW-1:0] trial;
    always_comb begin
      nx    = d_q[j];
      trial = NUMW'(d_q[j].den) << B;
      if (d_q[j].rem >= trial) begin
        nx.rem  = d_q[j].rem - trial;
        nx.q[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j+1] <= 1'b0;
      end else if (en_d[j+1]) begin
        vd_q[j+1] <= vd_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_d[j+1] && vd_q[j]) begin
        d_q[j+1] <= nx;
      end
    end
  end

  logic [30:0] dist_sel;
  always_comb begin
    if (d_q[QBITS].kind != KIND_HIT) begin
      dist_sel = '0;
    end else if (d_q[QBITS].sat) begin
      dist_sel = DIST_MAX;
    end else begin
      dist_sel = d_q[QBITS].q;
    end
    s5_d.pr_x     = d_q[QBITS].in.dir_x * $signed({1'b0, dist_sel});
    s5_d.pr_y     = d_q[QBITS].in.dir_y * $signed({1'b0, dist_sel});
    s5_d.pr_z     = d_q[QBITS].in.dir_z * $signed({1'b0, dist_sel});
    s5_d.side     = d_q[QBITS].side;
    s5_d.kind     = d_q[QBITS].kind;
    s5_d.dist_val = dist_sel;
    s5_d.in       = d_q[QBITS].in;
  end

  function automatic logic [31:0] hit_sat(logic [31:0] p, logic [63:0] pr);
    logic [48:0] s;
    s = {{17{p[31]}}, p} + {pr[63], pr[63:16]};
    if (!s[48] && (s[47:31] != '0)) begin
      return 32'h7fffffff;
    end else if (s[48] && (s[47:31] != '1)) begin
      return 32'h80000000;
    end
    return s[31:0];
  endfunction

  always_comb begin
    o_d.side     = s5_q.side;
    o_d.hit_kind = s5_q.kind;
    o_d.distance = s5_q.dist_val;
    if (s5_q.kind == KIND_HIT) begin
      o_d.hit_x = hit_sat(s5_q.in.pos_x, s5_q.pr_x);
      o_d.hit_y = hit_sat(s5_q.in.pos_y, s5_q.pr_y);
      o_d.hit_z = hit_sat(s5_q.in.pos_z, s5_q.pr_z);
    end else begin
      o_d.hit_x = '0;
      o_d.hit_y = '0;
      o_d.hit_z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vd_q[0] <= 1'b0;
      v5_q    <= 1'b0;
      vo_q    <= 1'b0;
    end else begin
      if (en1)     v1_q    <= in_valid_i;
      if (en2)     v2_q    <= v1_q;
      if (en3)     v3_q    <= v2_q;
      if (en_d[0]) vd_q[0] <= v3_q;
      if (en5)     v5_q    <= vd_q[QBITS];
      if (en_o)    vo_q    <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
    if (en3 && v2_q) s3_q <= s3_d;
    if (en_d[0] && v3_q) d_q[0] <= d0_d;
    if (en5 && vd_q[QBITS]) s5_q <= s5_d;
    if (en_o && v5_q) o_q <= o_d;
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = o_q;

endmodule

// File: design/rpi_checker.sv
`include "ray_plane_intersect_unit_defines.svh"

module rpi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rpi_pkg::rpi_out_t out_data_o
);
  import rpi_pkg::*;

  // A waiting result beat stays until it is taken.
  `RPI_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // The input side only stalls when a result is backed up at the output.
  `RPI_ASSERT_IMP(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)

  // Without an intersection the distance and hit point are zero.
  `RPI_ASSERT_IMP(a_nohit_zero, out_valid_o && (out_data_o.hit_kind != KIND_HIT),
                  (out_data_o.distance == '0) && (out_data_o.hit_x == '0) &&
                  (out_data_o.hit_y == '0) && (out_data_o.hit_z == '0))

endmodule

bind ray_plane_intersect_unit rpi_checker u_rpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: dv/ray_plane_intersect_unit_tb.sv
`timescale 1ns / 100ps

module ray_plane_intersect_unit_tb;
  import rpi_pkg::*;

  typedef struct {
    rpi_in_t  beat;
    bit       known;
    rpi_out_t result;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  rpi_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rpi_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic signed [31:0] plane_org [3];
  logic signed [31:0] plane_nrm [3];
  logic        [30:0] tol_side;
  logic        [30:0] tol_par;

  rpi_out_t pending_results[$];
  dir_row_t dir_rows[$];
  int errors;
  int beats_done;
  int settings_done;
  int n_hit, n_par, n_behind;

  ray_plane_intersect_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [127:0] sx(input logic [31:0] v);
    return $signed({{96{v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic rpi_out_t intersect_ray(input rpi_in_t b);
    logic [31:0] p [3];
    logic [31:0] d [3];
    logic signed [127:0] k, l, ak, al, tol, q, h;
    rpi_out_t r;
    p[0] = b.pos_x; p[1] = b.pos_y; p[2] = b.pos_z;
    d[0] = b.dir_x; d[1] = b.dir_y; d[2] = b.dir_z;
    k = 0;
    l = 0;
    for (int i = 0; i < 3; i++) begin
      k = k + (sx(p[i]) - sx(plane_org[i])) * sx(plane_nrm[i]);
      l = l + sx(d[i]) * sx(plane_nrm[i]);
    end
    ak = (k < 0) ? -k : k;
    al = (l < 0) ? -l : l;
    r = '0;
    tol = $signed({97'b0, tol_side}) <<< 16;
    if (b.check_on_plane && ak <= tol) r.side = SIDE_ON;
    else if (k > 0) r.side = SIDE_POS;
    else r.side = SIDE_NEG;
    tol = $signed({97'b0, tol_par}) <<< 16;
    if (al <= tol || l == 0) begin
      r.hit_kind = KIND_PARALLEL;
    end else if (k == 0 || (k < 0) == (l < 0)) begin
      r.hit_kind = KIND_BEHIND;
    end else begin
      r.hit_kind = KIND_HIT;
      q = (ak <<< 16) / al;
      if (q > 128'sd2147483647) q = 128'sd2147483647;
      r.distance = q[30:0];
      h = sx(p[0]) + ((sx(d[0]) * q) >>> 16);
      r.hit_x = sat32(h);
      h = sx(p[1]) + ((sx(d[1]) * q) >>> 16);
      r.hit_y = sat32(h);
      h = sx(p[2]) + ((sx(d[2]) * q) >>> 16);
      r.hit_z = sat32(h);
    end
    return r;
  endfunction

  // Input side: predict on every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_results.push_back(intersect_ray(in_data_i));
    end
  end

  // Output side: compare each accepted beat with the oldest prediction.
  always @(posedge clk_i) begin
    rpi_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, out_data_o);
      end else begin
        e = pending_results.pop_front();
        beats_done++;
        case (e.hit_kind)
          KIND_HIT:      n_hit++;
          KIND_PARALLEL: n_par++;
          default:       n_behind++;
        endcase
        if (out_data_o.side !== e.side) begin
          errors++;
          $display("%0t: side expected %0d actual %0d", $time, e.side, out_data_o.side);
        end
        if (out_data_o.hit_kind !== e.hit_kind) begin
          errors++;
          $display("%0t: hit_kind expected %0d actual %0d", $time, e.hit_kind,
                   out_data_o.hit_kind);
        end
        if (out_data_o.distance !== e.distance) begin
          errors++;
          $display("%0t: distance expected %h actual %h", $time, e.distance,
                   out_data_o.distance);
        end
        if (out_data_o.hit_x !== e.hit_x) begin
          errors++;
          $display("%0t: hit_x expected %h actual %h", $time, e.hit_x, out_data_o.hit_x);
        end
        if (out_data_o.hit_y !== e.hit_y) begin
          errors++;
          $display("%0t: hit_y expected %h actual %h", $time, e.hit_y, out_data_o.hit_y);
        end
        if (out_data_o.hit_z !== e.hit_z) begin
          errors++;
          $display("%0t: hit_z expected %h actual %h", $time, e.hit_z, out_data_o.hit_z);
        end
      end
    end
  end

  // Receiver stalls on its own pattern, switching style every so often.
  int stall_mode, stall_left, stall_tick;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= $urandom_range(0, 1);
      2:       out_ready_i <= (stall_tick % 5) != 0;
      default: out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic write_reg(input rpi_reg_e r, input logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_ORIGIN_X: plane_org[0] = v;
      REG_ORIGIN_Y: plane_org[1] = v;
      REG_ORIGIN_Z: plane_org[2] = v;
      REG_NORMAL_X: plane_nrm[0] = v;
      REG_NORMAL_Y: plane_nrm[1] = v;
      REG_NORMAL_Z: plane_nrm[2] = v;
      REG_SIDE_TOL: tol_side = v[30:0];
      default:      tol_par = v[30:0];
    endcase
  endtask

  task automatic set_plane(input logic [31:0] o[3], input logic [31:0] n[3],
                           input logic [31:0] ts, input logic [31:0] tp);
    write_reg(REG_ORIGIN_X, o[0]);
    write_reg(REG_ORIGIN_Y, o[1]);
    write_reg(REG_ORIGIN_Z, o[2]);
    write_reg(REG_NORMAL_X, n[0]);
    write_reg(REG_NORMAL_Y, n[1]);
    write_reg(REG_NORMAL_Z, n[2]);
    write_reg(REG_SIDE_TOL, ts);
    write_reg(REG_PAR_TOL, tp);
    settings_done++;
  endtask

  int burst_left;

  task automatic send_beat(input rpi_in_t b);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3:       return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near(input logic [31:0] c);
    return c + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic rpi_in_t make_ray();
    rpi_in_t b;
    int m;
    m = $urandom_range(0, 9);
    b.check_on_plane = $urandom_range(0, 1);
    if (m == 0) begin
      b.pos_x = rand_word(); b.pos_y = rand_word(); b.pos_z = rand_word();
      b.dir_x = rand_word(); b.dir_y = rand_word(); b.dir_z = rand_word();
    end else begin
      if (m == 1) begin
        b.pos_x = plane_org[0]; b.pos_y = plane_org[1]; b.pos_z = plane_org[2];
      end else begin
        b.pos_x = near(plane_org[0]); b.pos_y = near(plane_org[1]);
        b.pos_z = near(plane_org[2]);
      end
      if (m == 2) begin
        b.dir_x = $urandom_range(0, 3) - 1; b.dir_y = 0; b.dir_z = $urandom_range(0, 1);
      end else begin
        b.dir_x = near(0); b.dir_y = near(0); b.dir_z = near(0);
        if ($urandom_range(0, 7) == 0) b.dir_x = $urandom;
      end
    end
    return b;
  endfunction

  task automatic add_row(input rpi_in_t b, input bit known, input rpi_out_t r);
    dir_row_t row;
    row.beat = b;
    row.known = known;
    row.result = r;
    dir_rows.push_back(row);
  endtask

  initial begin
    logic [31:0] o[3];
    logic [31:0] n[3];
    rpi_out_t pr;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    errors = 0; beats_done = 0; settings_done = 1;
    n_hit = 0; n_par = 0; n_behind = 0;
    stall_left = 0; stall_tick = 0; burst_left = 0;
    plane_org[0] = 0; plane_org[1] = 0; plane_org[2] = 0;
    plane_nrm[0] = 32'sd65536; plane_nrm[1] = 0; plane_nrm[2] = 0;
    tol_side = 0;
    tol_par  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_row('{0, 0, 0, 32'h10000, 0, 0, 1'b0}, 1,
            '{SIDE_NEG, KIND_BEHIND, 0, 0, 0, 0});
    add_row('{0, 0, 0, 32'h10000, 0, 0, 1'b1}, 1,
            '{SIDE_ON, KIND_BEHIND, 0, 0, 0, 0});
    add_row('{32'hffff0000, 0, 0, 32'h10000, 0, 0, 1'b0}, 1,
            '{SIDE_NEG, KIND_HIT, 31'h10000, 0, 0, 0});
    add_row('{32'h20000, 5, 0, 32'hffff0000, 0, 0, 1'b1}, 1,
            '{SIDE_POS, KIND_HIT, 31'h20000, 0, 5, 0});
    add_row('{32'h10000, 0, 0, 32'h10000, 0, 0, 1'b0}, 1,
            '{SIDE_POS, KIND_BEHIND, 0, 0, 0, 0});
    add_row('{32'hffff0000, 0, 0, 0, 0, 0, 1'b0}, 1,
            '{SIDE_NEG, KIND_PARALLEL, 0, 0, 0, 0});
    add_row('{32'hffff0000, 7, 9, 0, 32'h7fffffff, 32'h80000000, 1'b1}, 1,
            '{SIDE_NEG, KIND_PARALLEL, 0, 0, 0, 0});
    pr = '0;
    add_row('{32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 1'b0}, 0, pr);
    add_row('{32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 1'b1}, 0, pr);
    add_row('{32'h80000000, 32'h7fffffff, 32'h80000000, 1, 1, 1, 1'b0}, 0, pr);
    add_row('{32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h10000, 32'h7fffffff,
              32'h80000000, 1'b0}, 0, pr);
    add_row('{32'hffffffff, 0, 0, 32'h7fffffff, 0, 0, 1'b1}, 0, pr);
    add_row('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 1'b1}, 0, pr);
    add_row('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000, 1'b1}, 0, pr);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        pr = intersect_ray(dir_rows[i].beat);
        if (pr !== dir_rows[i].result) begin
          errors++;
          $display("%0t: row %0d expected %h predicted %h", $time, i,
                   dir_rows[i].result, pr);
        end
      end
      send_beat(dir_rows[i].beat);
    end
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) begin
        o = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        n = '{32'h80000000, 32'h80000000, 32'h80000000};
        set_plane(o, n, 32'hffffffff, 32'hffffffff);
      end else if (ph == 1) begin
        o = '{32'h80000000, 32'h80000000, 32'h80000000};
        n = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        set_plane(o, n, 32'h0, 32'h0);
      end else begin
        for (int j = 0; j < 3; j++) begin
          o[j] = rand_word();
          n[j] = ($urandom_range(0, 2) == 0) ? rand_word()
                                             : $urandom_range(0, 32'h20000) - 32'h10000;
        end
        set_plane(o, n,
                  ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h4000),
                  ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h400));
      end
      repeat (215) send_beat(make_ray());
      drain();
    end

    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Checked %0d result beats over %0d plane settings.", beats_done, settings_done);
    $display("Hits %0d, parallel %0d, behind %0d, mismatches %0d.", n_hit, n_par,
             n_behind, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: ray_plane_intersect_unit.f
+incdir+design
design/rpi_pkg.sv
design/ray_plane_intersect_unit.sv
design/rpi_checker.sv
dv/ray_plane_intersect_unit_tb.sv
